/* design/vng_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_pkg
// Shared types, widths and helpers of the vertex normal generator.
// ----------------------------------------------------------------------------
package vng_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 24;
  localparam int SUM_W  = 24;
  localparam int NRM_W  = 16;
  localparam int EDGE_W = POS_W + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int VEC_W  = 52;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TRD,
    S_EDGE,
    S_CROSS,
    S_FNORM,
    S_SUMRD,
    S_SUMWR,
    S_QRD,
    S_QNORM,
    S_RES
  } top_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DINIT,
    N_DIV,
    N_DONE
  } norm_state_e;

  typedef struct packed {
    logic signed [VEC_W-1:0] z;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] z;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] x;
  } nrm_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic signed [NRM_W-1:0] d
  );
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    // top two bits differ only when the sum left the 24-bit range
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

endpackage

/* design/vng_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_stream_if
// Valid/ready channels for command beats and normal result beats.
// ----------------------------------------------------------------------------
interface vng_in_if import vng_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;

  modport source (output valid, opcode, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, opcode, vertex_index, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface vng_out_if import vng_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

/* design/vng_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vng_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/vng_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_norm
// Iterative vector normalizer: range shift, sum of squares, bit-pair square
// root and restoring division to a Q1.15 unit vector.
// ----------------------------------------------------------------------------
module vng_norm import vng_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  vec_t  vec_i,
  output logic  done_o,
  output nrm_t  nrm_o
);

  localparam int MAG_W = VEC_W;
  localparam int ACC_W = 50;
  localparam int RT_W  = 25;
  localparam int DV_W  = 40;

  norm_state_e state_q, state_d;
  logic [MAG_W-1:0] mag_q [3];
  logic [MAG_W-1:0] mag_d [3];
  logic [2:0]       neg_q, neg_d;
  logic [1:0]       idx_q, idx_d;
  logic [47:0]      prod_q, prod_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] srem_q, srem_d;
  logic [ACC_W-1:0] res_q, res_d;
  logic [ACC_W-1:0] bit_q, bit_d;
  logic [RT_W-1:0]  r_q, r_d;
  logic [DV_W-1:0]  drem_q, drem_d;
  logic [DV_W-1:0]  dvs_q, dvs_d;
  logic [15:0]      quo_q, quo_d;
  logic [3:0]       k_q, k_d;
  nrm_t             nrm_q, nrm_d;

  logic signed [VEC_W-1:0] v [3];
  logic [MAG_W-1:0] mx;
  logic [MAG_W-1:0] sel;
  logic             sel_neg;
  logic [ACC_W-1:0] trial;
  logic [15:0]      qc;
  logic signed [NRM_W-1:0] nv;

  assign v[0] = vec_i.x;
  assign v[1] = vec_i.y;
  assign v[2] = vec_i.z;

  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  always_comb begin
    case (idx_q)
      2'd0:    begin sel = mag_q[0]; sel_neg = neg_q[0]; end
      2'd1:    begin sel = mag_q[1]; sel_neg = neg_q[1]; end
      default: begin sel = mag_q[2]; sel_neg = neg_q[2]; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    srem_d  = srem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    r_d     = r_q;
    drem_d  = drem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    k_d     = k_q;
    nrm_d   = nrm_q;
    done_o  = 1'b0;
    trial   = res_q + bit_q;
    qc      = '0;
    nv      = '0;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = v[i][VEC_W-1];
            mag_d[i] = v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
          end
          nrm_d = '0;
          if (v[0] == '0 && v[1] == '0 && v[2] == '0) begin
            state_d = N_DONE;
          end else begin
            state_d = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        // truncating right shifts compose, so coarse steps match single steps
        if (mx >= (MAG_W'(1) << 32)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 8;
        end else if (mx >= (MAG_W'(1) << 24)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (mx < (MAG_W'(1) << 15)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 8;
        end else if (mx < (MAG_W'(1) << 23)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (idx_q != 2'd3) begin
          prod_d = sel[23:0] * sel[23:0];
        end
        if (idx_q != 2'd0) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          srem_d  = acc_d;
          res_d   = '0;
          bit_d   = ACC_W'(1) << 48;
          state_d = N_SQRT;
        end
      end
      N_SQRT: begin
        if (bit_q == '0) begin
          r_d     = res_q[RT_W-1:0];
          idx_d   = '0;
          state_d = N_DINIT;
        end else begin
          if (srem_q >= trial) begin
            srem_d = srem_q - trial;
            res_d  = (res_q >> 1) + bit_q;
          end else begin
            res_d  = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      N_DINIT: begin
        // rounded quotient stays below 2^16, so sixteen trial subtracts
        drem_d  = {1'b0, sel[23:0], 15'd0} + DV_W'(r_q >> 1);
        dvs_d   = {r_q, 15'd0};
        quo_d   = '0;
        k_d     = '0;
        state_d = N_DIV;
      end
      N_DIV: begin
        if (drem_q >= dvs_q) begin
          drem_d = drem_q - dvs_q;
          quo_d  = {quo_q[14:0], 1'b1};
        end else begin
          quo_d  = {quo_q[14:0], 1'b0};
        end
        dvs_d = dvs_q >> 1;
        k_d   = k_q + 4'd1;
        if (k_q == 4'd15) begin
          qc = quo_d[15] ? 16'h7fff : quo_d;
          nv = sel_neg ? -$signed(qc) : $signed(qc);
          case (idx_q)
            2'd0:    nrm_d.x = nv;
            2'd1:    nrm_d.y = nv;
            default: nrm_d.z = nv;
          endcase
          if (idx_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = N_DINIT;
          end
        end
      end
      N_DONE: begin
        done_o  = 1'b1;
        state_d = N_IDLE;
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    srem_q <= srem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    r_q    <= r_d;
    drem_q <= drem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    k_q    <= k_d;
    nrm_q  <= nrm_d;
  end

  assign nrm_o = nrm_q;

endmodule

/* design/vertex_normal_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_generator_top
// Smooth per-vertex normals held in a position RAM and a normal sum RAM.
// ----------------------------------------------------------------------------
// load: written at the accepting edge
// triangle: three corner position reads, edge vectors and a cross product on
//   one shared multiplier, the normalizer, then a sum update for each corner
// query: a sum RAM read, then the normalizer's square root and divisions
// one item at a time; a waiting result stalls only a query whose result is ready
// after reset all MAX_VERTICES sum RAM entries are cleared, ready stays low
module vertex_normal_generator_top import vng_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vng_in_if.sink        in_i,
  vng_out_if.source     out_o
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int RW  = 3 * SUM_W;

  top_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0]    step_q, step_d;
  logic [1:0]    cidx_q, cidx_d;
  logic [AW-1:0] ca_q, cb_q, cc_q, vi_q;
  logic [RW-1:0] pa_q, pb_q, pc_q, pa_d, pb_d, pc_d;
  logic signed [EDGE_W-1:0] e0_q [3];
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e0_d [3];
  logic signed [EDGE_W-1:0] e1_d [3];
  logic signed [PROD_W-1:0] prod_q, prod_d;
  vec_t cr_q, cr_d;
  nrm_t fn_q, fn_d;
  nrm_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  nrm_t out_q, out_d;

  logic accept;
  logic a_ok, b_ok, c_ok, v_ok;
  logic signed [EDGE_W-1:0] op_a, op_b;

  logic          pos_we;
  logic [AW-1:0] pos_raddr;
  logic [RW-1:0] pos_rdata, pos_wdata;
  logic          sum_we;
  logic [AW-1:0] sum_waddr, sum_raddr;
  logic [RW-1:0] sum_rdata, sum_wdata;

  logic      norm_start;
  logic      norm_done;
  vec_t      nvec;
  nrm_t      nres;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    idx_ok = ({22'd0, idx} < 32'(MAX_VERTICES));
  endfunction

  assign accept = in_i.valid && in_i.ready;
  assign a_ok   = idx_ok(in_i.corner_a);
  assign b_ok   = idx_ok(in_i.corner_b);
  assign c_ok   = idx_ok(in_i.corner_c);
  assign v_ok   = idx_ok(in_i.vertex_index);

  // position load happens at the accepting edge
  assign pos_we    = accept && (opcode_e'(in_i.opcode) == OP_LOAD) && v_ok;
  assign pos_wdata = {in_i.pos_z, in_i.pos_y, in_i.pos_x};

  vng_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (AW'(in_i.vertex_index)),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vng_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  assign nvec = (state_q == S_QNORM) ?
    vec_t'{z: VEC_W'($signed(sum_rdata[3*SUM_W-1:2*SUM_W])),
           y: VEC_W'($signed(sum_rdata[2*SUM_W-1:SUM_W])),
           x: VEC_W'($signed(sum_rdata[SUM_W-1:0]))} : cr_q;

  vng_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (nvec),
    .done_o  (norm_done),
    .nrm_o   (nres)
  );

  // cross product operand order: +y*z, -z*y, +z*x, -x*z, +x*y, -y*x
  always_comb begin
    case (step_q)
      3'd0:    begin op_a = e0_q[1]; op_b = e1_q[2]; end
      3'd1:    begin op_a = e0_q[2]; op_b = e1_q[1]; end
      3'd2:    begin op_a = e0_q[2]; op_b = e1_q[0]; end
      3'd3:    begin op_a = e0_q[0]; op_b = e1_q[2]; end
      3'd4:    begin op_a = e0_q[0]; op_b = e1_q[1]; end
      default: begin op_a = e0_q[1]; op_b = e1_q[0]; end
    endcase
  end

  always_comb begin
    logic [AW-1:0] corner;
    logic [RW-1:0] upd;
    state_d     = state_q;
    clr_d       = clr_q;
    step_d      = step_q;
    cidx_d      = cidx_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    pc_d        = pc_q;
    e0_d        = e0_q;
    e1_d        = e1_q;
    prod_d      = prod_q;
    cr_d        = cr_q;
    fn_d        = fn_q;
    res_d       = res_q;
    in_i.ready  = 1'b0;
    pos_raddr   = ca_q;
    sum_raddr   = ca_q;
    sum_we      = 1'b0;
    sum_waddr   = clr_q;
    sum_wdata   = '0;
    norm_start  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    upd         = '0;
    case (cidx_q)
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
    unique case (state_q)
      S_CLEAR: begin
        sum_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (opcode_e'(in_i.opcode))
            OP_LOAD: begin
              sum_we    = v_ok;
              sum_waddr = AW'(in_i.vertex_index);
            end
            OP_TRI: begin
              if (a_ok && b_ok && c_ok) begin
                step_d  = '0;
                state_d = S_TRD;
              end
            end
            OP_QUERY: begin
              if (v_ok) begin
                state_d = S_QRD;
              end else begin
                res_d   = '0;
                state_d = S_RES;
              end
            end
            default: ;
          endcase
        end
      end
      S_TRD: begin
        case (step_q)
          3'd0:    pos_raddr = ca_q;
          3'd1:    pos_raddr = cb_q;
          default: pos_raddr = cc_q;
        endcase
        if (step_q == 3'd1) pa_d = pos_rdata;
        if (step_q == 3'd2) pb_d = pos_rdata;
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          pc_d    = pos_rdata;
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e0_d[i] = EDGE_W'($signed(pb_q[i*POS_W +: POS_W]))
                  - EDGE_W'($signed(pa_q[i*POS_W +: POS_W]));
          e1_d[i] = EDGE_W'($signed(pc_q[i*POS_W +: POS_W]))
                  - EDGE_W'($signed(pa_q[i*POS_W +: POS_W]));
        end
        step_d  = '0;
        state_d = S_CROSS;
      end
      S_CROSS: begin
        if (step_q != 3'd6) begin
          prod_d = op_a * op_b;
        end
        case (step_q)
          3'd1: cr_d.x = VEC_W'(prod_q);
          3'd2: cr_d.x = cr_q.x - VEC_W'(prod_q);
          3'd3: cr_d.y = VEC_W'(prod_q);
          3'd4: cr_d.y = cr_q.y - VEC_W'(prod_q);
          3'd5: cr_d.z = VEC_W'(prod_q);
          3'd6: cr_d.z = cr_q.z - VEC_W'(prod_q);
          default: ;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          step_d  = '0;
          state_d = S_FNORM;
        end
      end
      S_FNORM: begin
        norm_start = (step_q == 3'd0);
        step_d     = 3'd1;
        if (norm_done) begin
          fn_d    = nres;
          cidx_d  = '0;
          state_d = S_SUMRD;
        end
      end
      S_SUMRD: begin
        // one corner at a time so a repeated corner sees its own update
        sum_raddr = corner;
        state_d   = S_SUMWR;
      end
      S_SUMWR: begin
        upd[SUM_W-1:0]         = sat_add(sum_rdata[SUM_W-1:0], fn_q.x);
        upd[2*SUM_W-1:SUM_W]   = sat_add(sum_rdata[2*SUM_W-1:SUM_W], fn_q.y);
        upd[3*SUM_W-1:2*SUM_W] = sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], fn_q.z);
        sum_we    = 1'b1;
        sum_waddr = corner;
        sum_wdata = upd;
        cidx_d    = cidx_q + 2'd1;
        state_d   = (cidx_q == 2'd2) ? S_IDLE : S_SUMRD;
      end
      S_QRD: begin
        sum_raddr = vi_q;
        step_d    = '0;
        state_d   = S_QNORM;
      end
      S_QNORM: begin
        sum_raddr  = vi_q;
        norm_start = (step_q == 3'd0);
        step_d     = 3'd1;
        if (norm_done) begin
          res_d   = nres;
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      cidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      cidx_q      <= cidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ca_q <= AW'(in_i.corner_a);
      cb_q <= AW'(in_i.corner_b);
      cc_q <= AW'(in_i.corner_c);
      vi_q <= AW'(in_i.vertex_index);
    end
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    pc_q   <= pc_d;
    e0_q   <= e0_d;
    e1_q   <= e1_d;
    prod_q <= prod_d;
    cr_q   <= cr_d;
    fn_q   <= fn_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.normal_x = out_q.x;
  assign out_o.normal_y = out_q.y;
  assign out_o.normal_z = out_q.z;

endmodule
